@@ hdl/evad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_pkg
// Shared types and constants for the energy voice activity detector.
// ----------------------------------------------------------------------------
package evad_pkg;

    localparam int unsigned THR_W = 31;   // energy and threshold width
    localparam int unsigned RUN_W = 8;    // run counters and frame limits
    localparam int unsigned SMP_W = 16;   // PCM sample width
    localparam int unsigned SQ_W  = 32;   // one squared sample

    // Configuration register indexes
    localparam logic [1:0] REG_SPEECH_THR   = 2'd0;
    localparam logic [1:0] REG_SILENCE_THR  = 2'd1;
    localparam logic [1:0] REG_SPEECH_NEED  = 2'd2;
    localparam logic [1:0] REG_SILENCE_NEED = 2'd3;

    // Configuration reset values
    localparam logic [THR_W-1:0] RST_SPEECH_THR   = 31'd1500;
    localparam logic [THR_W-1:0] RST_SILENCE_THR  = 31'd500;
    localparam logic [RUN_W-1:0] RST_SPEECH_NEED  = 8'd3;
    localparam logic [RUN_W-1:0] RST_SILENCE_NEED = 8'd10;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POST
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic acc_en;    // accumulate the accepted sample
        logic load_div;  // frame closes: start the divide
        logic div_step;  // one restoring divide step
        logic post;      // hysteresis update and output load
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic frame_end;  // the sample on the input closes a frame
        logic out_busy;   // output register full and not taken this cycle
    } t_dp_stat;

endpackage

@@ hdl/evad_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_ctrl
// Sequencer: input flow control, divide step count, result hand-off.
// ----------------------------------------------------------------------------
module evad_ctrl #(
    parameter int unsigned SUM_W = 41
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  evad_pkg::t_dp_stat i_stat,
    output evad_pkg::t_dp_cmd  o_cmd
);
    import evad_pkg::*;

    localparam int unsigned STEP_W = $clog2(SUM_W);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        // only a frame-closing sample has to wait for the divider and the result hand-off
        o_in_stall   = (r_state != ST_IDLE) && i_stat.frame_end;
        o_cmd.acc_en = i_in_valid && !o_in_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.acc_en && i_stat.frame_end) begin
                    o_cmd.load_div = 1'b1;
                    n_step         = STEP_W'(SUM_W - 1);
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_POST;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            ST_POST: begin
                if (!i_stat.out_busy) begin
                    o_cmd.post = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ hdl/evad_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_dp
// Datapath: square accumulator, restoring divider, hysteresis, output register.
// ----------------------------------------------------------------------------
module evad_dp #(
    parameter int unsigned MAX_FRAME_SAMPLES = 1024,
    parameter int unsigned CNT_W             = 11,
    parameter int unsigned SUM_W             = 41
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [evad_pkg::THR_W-1:0]  i_cfg_data,
    input  logic signed [evad_pkg::SMP_W-1:0] i_sample,
    input  logic                        i_last_in_frame,
    input  logic                        i_out_stall,
    input  evad_pkg::t_dp_cmd           i_cmd,
    output evad_pkg::t_dp_stat          o_stat,
    output logic                        o_out_valid,
    output logic                        o_in_speech,
    output logic [evad_pkg::THR_W-1:0]  o_frame_energy,
    output logic [1:0]                  o_event_res
);
    import evad_pkg::*;

    // configuration
    logic [THR_W-1:0] r_speech_thr, r_silence_thr;
    logic [RUN_W-1:0] r_speech_need, r_silence_need;

    // accumulation
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;

    // divider
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_div;
    logic [CNT_W-1:0] r_rem;

    // hysteresis
    logic             r_mode;
    logic [RUN_W-1:0] r_loud, r_quiet;
    logic             n_mode;
    logic [RUN_W-1:0] n_loud, n_quiet;
    t_event           n_event;

    logic             r_out_valid;

    logic [SMP_W-1:0] w_mag;
    logic [SQ_W-1:0]  w_sq;
    logic [SUM_W-1:0] w_sum_inc;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [CNT_W:0]   w_shift;
    logic             w_ge;
    logic [CNT_W:0]   w_diff;
    logic [THR_W-1:0] w_energy;
    logic [RUN_W-1:0] w_loud_bump, w_quiet_bump;

    // -32768 wraps to 0x8000, which is its magnitude as unsigned
    assign w_mag     = i_sample[SMP_W-1] ? (SMP_W'(0) - $unsigned(i_sample))
                                         : $unsigned(i_sample);
    assign w_sq      = {{(SQ_W-SMP_W){1'b0}}, w_mag} * {{(SQ_W-SMP_W){1'b0}}, w_mag};
    assign w_sum_inc = r_sum + SUM_W'(w_sq);
    assign w_cnt_inc = r_count + CNT_W'(1);

    assign o_stat.frame_end = i_last_in_frame || (w_cnt_inc == CNT_W'(MAX_FRAME_SAMPLES));
    assign o_stat.out_busy  = r_out_valid && i_out_stall;

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    assign w_energy     = r_quo[THR_W-1:0];
    assign w_loud_bump  = (r_loud  < RUN_MAX) ? r_loud  + RUN_W'(1) : RUN_MAX;
    assign w_quiet_bump = (r_quiet < RUN_MAX) ? r_quiet + RUN_W'(1) : RUN_MAX;

    always_comb begin
        n_mode  = r_mode;
        n_loud  = r_loud;
        n_quiet = r_quiet;
        n_event = EV_NONE;
        if (!r_mode) begin
            if (w_energy > r_speech_thr) begin
                n_loud = w_loud_bump;
                if (w_loud_bump >= r_speech_need) begin
                    n_mode  = 1'b1;
                    n_quiet = '0;
                    n_event = EV_START;
                end
            end else begin
                n_loud = '0;
            end
        end else begin
            if (w_energy < r_silence_thr) begin
                n_quiet = w_quiet_bump;
                if (w_quiet_bump >= r_silence_need) begin
                    n_mode  = 1'b0;
                    n_loud  = '0;
                    n_event = EV_END;
                end
            end else begin
                n_quiet = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speech_thr   <= RST_SPEECH_THR;
            r_silence_thr  <= RST_SILENCE_THR;
            r_speech_need  <= RST_SPEECH_NEED;
            r_silence_need <= RST_SILENCE_NEED;
            r_sum          <= '0;
            r_count        <= '0;
            r_mode         <= 1'b0;
            r_loud         <= '0;
            r_quiet        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SPEECH_THR:   r_speech_thr   <= i_cfg_data;
                    REG_SILENCE_THR:  r_silence_thr  <= i_cfg_data;
                    REG_SPEECH_NEED:  r_speech_need  <= i_cfg_data[RUN_W-1:0];
                    REG_SILENCE_NEED: r_silence_need <= i_cfg_data[RUN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.acc_en) begin
                if (o_stat.frame_end) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= w_sum_inc;
                    r_count <= w_cnt_inc;
                end
            end
            if (i_cmd.post) begin
                r_mode      <= n_mode;
                r_loud      <= n_loud;
                r_quiet     <= n_quiet;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo <= w_sum_inc;
            r_div <= w_cnt_inc;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
        if (i_cmd.post) begin
            o_in_speech    <= n_mode;
            o_frame_energy <= w_energy;
            o_event_res    <= n_event;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/energy_voice_activity_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_voice_activity_detector
// Frame energy from PCM samples with speech/silence hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one signed sample per
//   transaction plus a frame-end mark; a frame also closes on its
//   MAX_FRAME_SAMPLES-th sample. Samples are taken one per cycle while not stalled.
//   Output channel (o_out_valid / i_out_stall) carries one result per frame:
//   state, truncated mean energy and start/end event.
//   Each frame's mean is formed by the one-bit-per-cycle restoring divider on
//   the SUM_W-bit sum (SUM_W = 30 + clog2(MAX_FRAME_SAMPLES + 1), 41 at the
//   default); the hysteresis step then loads the output register.
//   Accumulation of the next frame runs during the divide; only a frame's
//   closing sample is stalled while the previous frame is still in the
//   divider or hysteresis step, so frames of SUM_W + 2 samples or more flow
//   at one sample per cycle while the output is not stalled.
//   A stalled result stays in the output register; a further frame result
//   waits in the sequencer until that register is taken.
//   Reset (synchronous, active low) restores the default thresholds and
//   frame limits, clears the accumulator and starts in silence.
//   Configuration writes are taken in any cycle, intended while idle.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector #(
    parameter int unsigned MAX_FRAME_SAMPLES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [evad_pkg::THR_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [evad_pkg::SMP_W-1:0] i_sample,
    input  logic                              i_last_in_frame,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_in_speech,
    output logic [evad_pkg::THR_W-1:0]        o_frame_energy,
    output logic [1:0]                        o_event_res
);
    import evad_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int unsigned SUM_W = 30 + CNT_W;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    evad_ctrl #(
        .SUM_W(SUM_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    evad_dp #(
        .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
        .CNT_W            (CNT_W),
        .SUM_W            (SUM_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_sample),
        .i_last_in_frame (i_last_in_frame),
        .i_out_stall     (i_out_stall),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_in_speech     (o_in_speech),
        .o_frame_energy  (o_frame_energy),
        .o_event_res     (o_event_res)
    );

endmodule
